// ===== rtl/cpot_pkg.sv =====
// ----------------------------------------------------------------------------
// cpot_pkg
// Shared constants, types and state codes of the convex polygon overlap test.
// ----------------------------------------------------------------------------
package cpot_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int COORD_WIDTH = 16;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int AXIS_W = COORD_WIDTH + 1;
	localparam int PROD_W = AXIS_W + COORD_WIDTH;
	localparam int DOT_W = PROD_W + 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} vertex_t;

	typedef struct packed {
		logic shift;
		vertex_t din;
	} chain_ctl_t;

	typedef struct packed {
		logic valid;
		logic poly_b;
		logic first;
		vertex_t v;
	} feed_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_AXIS,
		ST_PROJ,
		ST_DRAIN,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/cpot_cell.sv =====
// ----------------------------------------------------------------------------
// cpot_cell
// One vertex slot of a polygon chain; takes its neighbor's vertex on a shift.
// ----------------------------------------------------------------------------
module cpot_cell
	import cpot_pkg::*;
(
	input  logic    clk,
	input  logic    shift,
	input  vertex_t din,
	output vertex_t dout
);

	vertex_t v_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			v_q <= din;
		end
	end

	assign dout = v_q;

endmodule

// ===== rtl/cpot_chain.sv =====
// ----------------------------------------------------------------------------
// cpot_chain
// Row of vertex cells for one polygon; loads at the head and rotates over
// the occupied cells so that every vertex passes the tail in turn.
// ----------------------------------------------------------------------------
module cpot_chain
	import cpot_pkg::*;
(
	input  logic             clk,
	input  chain_ctl_t       ctl,
	input  logic [CNT_W-1:0] count,
	output vertex_t          tail,
	output vertex_t          prev
);

	vertex_t cells [MAX_VERTICES];
	logic [CNT_W-1:0] nm1;
	logic [CNT_W-1:0] nm2;

	genvar i;
	generate
		for (i = 0; i < MAX_VERTICES; i++) begin : g_cell
			if (i == 0) begin : g_head
				cpot_cell u_cell (.clk(clk), .shift(ctl.shift), .din(ctl.din),
					.dout(cells[i]));
			end else begin : g_body
				cpot_cell u_cell (.clk(clk), .shift(ctl.shift), .din(cells[i-1]),
					.dout(cells[i]));
			end
		end
	endgenerate

	assign nm1 = count - CNT_W'(1);
	assign nm2 = count - CNT_W'(2);
	assign tail = cells[nm1[IDX_W-1:0]];
	assign prev = (count > CNT_W'(1)) ? cells[nm2[IDX_W-1:0]] : tail;

endmodule

// ===== rtl/cpot_proj.sv =====
// ----------------------------------------------------------------------------
// cpot_proj
// Projection unit: dot product of a vertex with the axis, then running
// minimum and maximum for each polygon.
// ----------------------------------------------------------------------------
module cpot_proj
	import cpot_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  feed_t                    feed,
	input  logic signed [AXIS_W-1:0] ax,
	input  logic signed [AXIS_W-1:0] ay,
	output logic signed [DOT_W-1:0]  lo_a,
	output logic signed [DOT_W-1:0]  hi_a,
	output logic signed [DOT_W-1:0]  lo_b,
	output logic signed [DOT_W-1:0]  hi_b
);

	logic signed [PROD_W-1:0] px_s1, py_s1;
	logic valid_s1, poly_b_s1, first_s1;
	logic signed [DOT_W-1:0] dot_s2;
	logic valid_s2, poly_b_s2, first_s2;
	logic signed [DOT_W-1:0] lo_a_q, hi_a_q, lo_b_q, hi_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= feed.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= ax * feed.v.x;
		py_s1 <= ay * feed.v.y;
		poly_b_s1 <= feed.poly_b;
		first_s1 <= feed.first;
		dot_s2 <= DOT_W'(px_s1) + DOT_W'(py_s1);
		poly_b_s2 <= poly_b_s1;
		first_s2 <= first_s1;
		if (valid_s2 && !poly_b_s2) begin
			if (first_s2 || dot_s2 < lo_a_q) lo_a_q <= dot_s2;
			if (first_s2 || dot_s2 > hi_a_q) hi_a_q <= dot_s2;
		end
		if (valid_s2 && poly_b_s2) begin
			if (first_s2 || dot_s2 < lo_b_q) lo_b_q <= dot_s2;
			if (first_s2 || dot_s2 > hi_b_q) hi_b_q <= dot_s2;
		end
	end

	assign lo_a = lo_a_q;
	assign hi_a = hi_a_q;
	assign lo_b = lo_b_q;
	assign hi_b = hi_b_q;

endmodule

// ===== rtl/convex_polygon_overlap_test.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_overlap_test
// Separating axis overlap test of two convex polygons loaded vertex by vertex.
// ----------------------------------------------------------------------------
// Each input word carries one vertex and the polygon it belongs to. Vertices
// are taken one per cycle into two rows of cells, up to MAX_VERTICES each;
// extra vertices are dropped and flag overflow_error. A word with
// final_vertex set stores its vertex and starts the test; no word is taken
// until the result word has been loaded into the output register.
// The test runs over every edge normal of A, and of B when B has more than
// one vertex. Each axis takes a setup state, a pass of all na + nb vertices
// through the shared projection multipliers (the rows rotate one vertex per
// cycle), a drain of the projection pipeline and a check state; the test
// ends early at the first separating axis.
// The result word holds overlap and overflow_error and stays on the output
// while stall is high; after it both polygons are empty again.
// Reset empties both polygons and clears the overflow flag.
// ----------------------------------------------------------------------------
module convex_polygon_overlap_test
	import cpot_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          polygon_select,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic                          final_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          overlap,
	output logic                          overflow_error
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] na_q, nb_q, axis_cnt_q, proj_cnt_q;
	logic axis_b_q, proj_b_q, ovf_q, result_q, drain_q;
	logic out_valid_q, overlap_q, ovf_out_q;
	logic signed [AXIS_W-1:0] ax_q, ay_q;
	chain_ctl_t ctl_a, ctl_b;
	vertex_t in_v, tail_a, prev_a, tail_b, prev_b, ax_tail, ax_prev;
	feed_t feed;
	logic signed [DOT_W-1:0] lo_a, hi_a, lo_b, hi_b;
	logic accept, a_full, b_full, separated;
	logic [CNT_W-1:0] ne, np;

	assign in_v.x = vertex_x;
	assign in_v.y = vertex_y;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign a_full = (na_q == CNT_W'(MAX_VERTICES));
	assign b_full = (nb_q == CNT_W'(MAX_VERTICES));
	assign ne = axis_b_q ? nb_q : na_q;
	assign np = proj_b_q ? nb_q : na_q;
	assign ax_tail = axis_b_q ? tail_b : tail_a;
	assign ax_prev = axis_b_q ? prev_b : prev_a;
	assign separated = (hi_a < lo_b) || (lo_a > hi_b);

	cpot_chain u_chain_a (.clk(clk), .ctl(ctl_a), .count(na_q), .tail(tail_a),
		.prev(prev_a));
	cpot_chain u_chain_b (.clk(clk), .ctl(ctl_b), .count(nb_q), .tail(tail_b),
		.prev(prev_b));

	cpot_proj u_proj (.clk(clk), .arst_n(arst_n), .feed(feed), .ax(ax_q),
		.ay(ay_q), .lo_a(lo_a), .hi_a(hi_a), .lo_b(lo_b), .hi_b(hi_b));

	always_comb begin
		state_d = state_q;
		ctl_a.shift = 1'b0;
		ctl_a.din = tail_a;
		ctl_b.shift = 1'b0;
		ctl_b.din = tail_b;
		feed.valid = 1'b0;
		feed.poly_b = proj_b_q;
		feed.first = (proj_cnt_q == '0);
		feed.v = proj_b_q ? tail_b : tail_a;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl_a.din = in_v;
					ctl_b.din = in_v;
					ctl_a.shift = !polygon_select && !a_full;
					ctl_b.shift = polygon_select && !b_full;
					if (final_vertex) state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = (na_q == '0 || nb_q == '0) ? ST_FINISH : ST_AXIS;
			end
			ST_AXIS: begin
				ctl_a.shift = !axis_b_q;
				ctl_b.shift = axis_b_q;
				state_d = ST_PROJ;
			end
			ST_PROJ: begin
				feed.valid = 1'b1;
				ctl_a.shift = !proj_b_q;
				ctl_b.shift = proj_b_q;
				if (proj_b_q && proj_cnt_q == nb_q - CNT_W'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_q) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (separated) begin
					state_d = ST_FINISH;
				end else if (axis_cnt_q == ne - CNT_W'(1)) begin
					state_d = (!axis_b_q && nb_q > CNT_W'(1)) ? ST_AXIS : ST_FINISH;
				end else begin
					state_d = ST_AXIS;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			na_q <= '0;
			nb_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			axis_cnt_q <= '0;
			proj_cnt_q <= '0;
			axis_b_q <= 1'b0;
			proj_b_q <= 1'b0;
			drain_q <= 1'b0;
			result_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (ctl_a.shift) na_q <= na_q + CNT_W'(1);
						if (ctl_b.shift) nb_q <= nb_q + CNT_W'(1);
						if ((polygon_select && b_full) || (!polygon_select && a_full)) begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					result_q <= 1'b0;
					axis_b_q <= 1'b0;
					axis_cnt_q <= '0;
				end
				ST_AXIS: begin
					proj_b_q <= 1'b0;
					proj_cnt_q <= '0;
				end
				ST_PROJ: begin
					if (proj_cnt_q == np - CNT_W'(1)) begin
						proj_b_q <= 1'b1;
						proj_cnt_q <= '0;
					end else begin
						proj_cnt_q <= proj_cnt_q + CNT_W'(1);
					end
					drain_q <= 1'b0;
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
				end
				ST_CHECK: begin
					if (separated) begin
						result_q <= 1'b0;
					end else if (axis_cnt_q == ne - CNT_W'(1)) begin
						axis_cnt_q <= '0;
						axis_b_q <= 1'b1;
						result_q <= !(!axis_b_q && nb_q > CNT_W'(1));
					end else begin
						axis_cnt_q <= axis_cnt_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						na_q <= '0;
						nb_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_AXIS) begin
			ax_q <= AXIS_W'(ax_prev.y) - AXIS_W'(ax_tail.y);
			ay_q <= AXIS_W'(ax_tail.x) - AXIS_W'(ax_prev.x);
		end
		if (state_q == ST_FINISH && (!out_valid_q || !out_stall)) begin
			overlap_q <= result_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign overlap = overlap_q;
	assign overflow_error = ovf_out_q;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the convex polygon overlap test.
// ----------------------------------------------------------------------------
// Vertex words are sent with random gaps and the result side stalls at
// random. A predictor in the bench keeps its own copy of both polygons and
// works out each overlap word exactly. Each received word is checked against
// the oldest expected word in order.
// ----------------------------------------------------------------------------
module tb_top;
	import cpot_pkg::*;

	typedef struct {
		logic hit;
		logic dropped;
	} verdict_t;

	typedef struct {
		longint x;
		longint y;
	} point_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic polygon_select;
	logic signed [COORD_WIDTH-1:0] vertex_x;
	logic signed [COORD_WIDTH-1:0] vertex_y;
	logic final_vertex;
	logic out_valid;
	logic out_stall;
	logic overlap;
	logic overflow_error;

	point_t poly_a[MAX_VERTICES];
	point_t poly_b[MAX_VERTICES];
	int count_a;
	int count_b;
	bit dropped_seen;
	verdict_t pending_verdicts[$];
	int mismatches;
	int received;
	int out_wait;
	longint cycles;
	bit sending_done;

	convex_polygon_overlap_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.polygon_select(polygon_select),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.final_vertex(final_vertex),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.overlap(overlap),
		.overflow_error(overflow_error)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void span(input point_t p[MAX_VERTICES], input int n,
			input longint ax, input longint ay, output longint lo, output longint hi);
		longint d;
		lo = p[0].x * ax + p[0].y * ay;
		hi = lo;
		for (int i = 1; i < n; i++) begin
			d = p[i].x * ax + p[i].y * ay;
			if (d > hi) hi = d;
			if (d < lo) lo = d;
		end
	endfunction

	function automatic bit axis_gap(input point_t e[MAX_VERTICES], input int ne);
		int prev;
		longint dx, dy, loa, hia, lob, hib;
		for (int k = 0; k < ne; k++) begin
			prev = (k == 0) ? ne - 1 : k - 1;
			dx = e[k].x - e[prev].x;
			dy = e[k].y - e[prev].y;
			span(poly_a, count_a, -dy, dx, loa, hia);
			span(poly_b, count_b, -dy, dx, lob, hib);
			if (hia < lob || loa > hib) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void load_vertex(input logic sel, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic fin);
		point_t v;
		verdict_t r;
		v.x = x;
		v.y = y;
		if (sel) begin
			if (count_b < MAX_VERTICES) poly_b[count_b++] = v;
			else dropped_seen = 1'b1;
		end else begin
			if (count_a < MAX_VERTICES) poly_a[count_a++] = v;
			else dropped_seen = 1'b1;
		end
		if (fin) begin
			if (count_a == 0 || count_b == 0) r.hit = 1'b0;
			else if (axis_gap(poly_a, count_a)) r.hit = 1'b0;
			else if (count_b > 1 && axis_gap(poly_b, count_b)) r.hit = 1'b0;
			else r.hit = 1'b1;
			r.dropped = dropped_seen;
			pending_verdicts = {pending_verdicts, r};
			count_a = 0;
			count_b = 0;
			dropped_seen = 1'b0;
		end
	endfunction

	task automatic send_vertex(input int sel, input int x, input int y, input int fin);
		int gap;
		logic sel_b;
		logic signed [15:0] xs;
		logic signed [15:0] ys;
		logic fin_b;
		sel_b = 1'(sel);
		xs = 16'(x);
		ys = 16'(y);
		fin_b = 1'(fin);
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		polygon_select <= sel_b;
		vertex_x <= xs;
		vertex_y <= ys;
		final_vertex <= fin_b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		load_vertex(sel_b, xs, ys, fin_b);
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	// Sends a regular polygon-like convex shape around a center.
	task automatic send_shape(input int sel, input int n, input int cx, input int cy,
			input int r, input logic fin_last);
		int x, y, fin;
		real ang;
		for (int i = 0; i < n; i++) begin
			ang = 6.2831853 * i / n;
			x = cx + $rtoi(r * $cos(ang));
			y = cy + $rtoi(r * $sin(ang));
			if (x > 32767) x = 32767;
			if (x < -32768) x = -32768;
			if (y > 32767) y = 32767;
			if (y < -32768) y = -32768;
			fin = (fin_last && i == n - 1) ? 1 : 0;
			send_vertex(sel, x, y, fin);
		end
	endtask

	task automatic test_directed();
		send_vertex(0, 0, 0, 0); send_vertex(0, 10, 0, 0); send_vertex(0, 0, 10, 0);
		send_vertex(1, 2, 2, 1);
		send_vertex(0, 0, 0, 0); send_vertex(0, 10, 0, 0); send_vertex(0, 0, 10, 0);
		send_vertex(1, 20, 20, 1);
		send_vertex(0, 16'sh8000, 16'sh8000, 0); send_vertex(0, 16'sh7fff, 16'sh8000, 0);
		send_vertex(0, 16'sh7fff, 16'sh7fff, 0);
		send_vertex(1, 16'sh8000, 16'sh7fff, 0); send_vertex(1, 16'sh7fff, 16'sh7fff, 1);
		send_vertex(1, 5, 5, 1);
		send_vertex(0, 3, 3, 0); send_vertex(0, 3, 3, 0);
		send_vertex(1, 3, 3, 0); send_vertex(0, 4, 4, 1);
		for (int i = 0; i < 10; i++) send_vertex(0, i, i * i, 0);
		send_vertex(1, 1, 1, 1);
		send_vertex(0, 7, 7, 1);
	endtask

	task automatic test_random_shapes();
		int na, nb, ra;
		for (int t = 0; t < 80; t++) begin
			na = $urandom_range(1, 10);
			nb = $urandom_range(1, 10);
			ra = $urandom_range(1, 9000);
			send_shape(0, na, $urandom_range(0, 20000) - 10000,
				$urandom_range(0, 20000) - 10000, ra, 0);
			send_shape(1, nb, $urandom_range(0, 40000) - 20000,
				$urandom_range(0, 40000) - 20000, $urandom_range(1, 9000), 1);
		end
	endtask

	task automatic test_random_noise();
		for (int t = 0; t < 250; t++)
			send_vertex($urandom_range(0, 1), rand_coord(), rand_coord(),
				($urandom_range(0, 4) == 0) ? 1 : 0);
		send_vertex(1, rand_coord(), rand_coord(), 1);
	endtask

	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (out_valid && !out_stall) begin
				received <= received + 1;
				if (pending_verdicts.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) $display("unexpected result word");
				end else begin
					exp_v = pending_verdicts.pop_front();
					if (overlap !== exp_v.hit || overflow_error !== exp_v.dropped) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: overlap %0b/%0b overflow %0b/%0b (exp/act)",
								exp_v.hit, overlap, exp_v.dropped, overflow_error);
					end
				end
				out_wait = $urandom_range(0, 3);
			end else if (out_wait > 0) begin
				out_wait = out_wait - 1;
			end
			out_stall <= (out_wait != 0);
			if (cycles > 2000000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		polygon_select = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		final_vertex = 1'b0;
		count_a = 0;
		count_b = 0;
		dropped_seen = 1'b0;
		mismatches = 0;
		received = 0;
		out_wait = 0;
		cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_shapes();
		test_random_noise();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
